// ===== hw/rtl/cdfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock date field adjuster package
// Shared codes, item types and the unit stepping helpers.
// ----------------------------------------------------------------------------
package cdfa_pkg;

    // Event codes
    localparam logic ACT_ADJUST = 1'b0;
    localparam logic ACT_TOGGLE = 1'b1;

    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    localparam logic SCREEN_TIME = 1'b0;
    localparam logic SCREEN_DATE = 1'b1;

    typedef enum logic [1:0] {
        UNIT_HOUR_DAY   = 2'd0,
        UNIT_MIN_MONTH  = 2'd1,
        UNIT_SEC_YEAR   = 2'd2,
        UNIT_NONE       = 2'd3
    } t_unit;

    // Field limits
    localparam logic [6:0] HOUR_TOP  = 7'd23;
    localparam logic [6:0] MIN_TOP   = 7'd59;
    localparam logic [6:0] MONTH_TOP = 7'd12;
    localparam logic [6:0] YEAR_TOP  = 7'd99;

    localparam logic [4:0] DAYS_LONG  = 5'd31;
    localparam logic [4:0] DAYS_SHORT = 5'd30;
    localparam logic [4:0] DAYS_LEAP  = 5'd29;
    localparam logic [4:0] DAYS_FEB   = 5'd28;

    typedef struct packed {
        logic       action;
        logic       direction;
        logic [1:0] unit_select;
        logic [4:0] cur_hours;
        logic [5:0] cur_minutes;
        logic [5:0] cur_seconds;
        logic [4:0] cur_day;
        logic [3:0] cur_month;
        logic [6:0] cur_year;
    } t_in_item;

    typedef struct packed {
        logic       screen;
        logic       write_time;
        logic       write_date;
        logic [4:0] new_hours;
        logic [5:0] new_minutes;
        logic [5:0] new_seconds;
        logic [4:0] new_day;
        logic [3:0] new_month;
        logic [6:0] new_year;
    } t_result;

    // Step a value by one with wrap. Down wraps to top at or below low, or
    // above top; up wraps to wrap_val at or above top.
    function automatic logic [6:0] f_step(
        input logic [6:0] v,
        input logic [6:0] low,
        input logic [6:0] top,
        input logic [6:0] wrap_val,
        input logic       down
    );
        logic [6:0] res;
        if (down == DIR_DOWN) begin
            res = (v <= low || v > top) ? top : v - 7'd1;
        end else begin
            res = (v >= top) ? wrap_val : v + 7'd1;
        end
        return res;
    endfunction

    // Days in a month; unknown month codes count as thirty days
    function automatic logic [4:0] f_month_limit(
        input logic [3:0] month,
        input logic       leap
    );
        logic [4:0] lim;
        case (month) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: lim = DAYS_LONG;
            4'd2:    lim = leap ? DAYS_LEAP : DAYS_FEB;
            default: lim = DAYS_SHORT;
        endcase
        return lim;
    endfunction

endpackage

// ===== hw/rtl/clock_date_field_adjuster_top.sv =====
// ----------------------------------------------------------------------------
// Clock date field adjuster
// Steps time or date fields on button events and toggles the shown screen.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one button event beat
//   with the current time and date read from the clock. Output channel
//   (o_out_valid / i_out_ready) returns one result beat per event: the
//   screen after the event, write flags and the fields to write back.
//   Fields of a group whose write flag is low read as zero.
//   Path: input register, then result register, which drives result
//   valid. Throughput: one event per cycle while the receiver keeps up;
//   the adjust logic is a single short pass between the two registers.
//   A stalled receiver holds the result register; the input register still
//   takes one more beat, after which o_in_ready drops until the result
//   drains.
//   Reset empties both registers and selects the time screen.
// ----------------------------------------------------------------------------
module clock_date_field_adjuster_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_action,
    input  logic       i_direction,
    input  logic [1:0] i_unit_select,
    input  logic [4:0] i_cur_hours,
    input  logic [5:0] i_cur_minutes,
    input  logic [5:0] i_cur_seconds,
    input  logic [4:0] i_cur_day,
    input  logic [3:0] i_cur_month,
    input  logic [6:0] i_cur_year,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_screen,
    output logic       o_write_time,
    output logic       o_write_date,
    output logic [4:0] o_new_hours,
    output logic [5:0] o_new_minutes,
    output logic [5:0] o_new_seconds,
    output logic [4:0] o_new_day,
    output logic [3:0] o_new_month,
    output logic [6:0] o_new_year
);

    logic                r_in_valid;
    cdfa_pkg::t_in_item  r_in;
    logic                r_out_valid;
    cdfa_pkg::t_result   r_out;
    logic                r_screen;

    logic                n_screen;
    cdfa_pkg::t_result   n_out;
    cdfa_pkg::t_in_item  in_item;
    logic                out_take;
    logic [4:0]          day_lim;

    // Pack the input beat
    assign in_item = '{
        action:      i_action,
        direction:   i_direction,
        unit_select: i_unit_select,
        cur_hours:   i_cur_hours,
        cur_minutes: i_cur_minutes,
        cur_seconds: i_cur_seconds,
        cur_day:     i_cur_day,
        cur_month:   i_cur_month,
        cur_year:    i_cur_year
    };

    // Handshake: each register advances when the one after it has room
    assign out_take   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || out_take;

    assign day_lim = cdfa_pkg::f_month_limit(r_in.cur_month, r_in.cur_year[1:0] == 2'b00);

    // Work out the screen and write-back fields for the held event
    always_comb begin
        n_screen = r_screen;
        n_out    = '0;
        if (r_in.action == cdfa_pkg::ACT_TOGGLE) begin
            n_screen = ~r_screen;
        end else if (cdfa_pkg::t_unit'(r_in.unit_select) != cdfa_pkg::UNIT_NONE) begin
            if (r_screen == cdfa_pkg::SCREEN_TIME) begin
                n_out.write_time  = 1'b1;
                n_out.new_hours   = r_in.cur_hours;
                n_out.new_minutes = r_in.cur_minutes;
                n_out.new_seconds = r_in.cur_seconds;
                case (cdfa_pkg::t_unit'(r_in.unit_select))
                    cdfa_pkg::UNIT_HOUR_DAY: begin
                        n_out.new_hours = 5'(cdfa_pkg::f_step(7'(r_in.cur_hours), 7'd0,
                            cdfa_pkg::HOUR_TOP, 7'd0, r_in.direction));
                    end
                    cdfa_pkg::UNIT_MIN_MONTH: begin
                        n_out.new_minutes = 6'(cdfa_pkg::f_step(7'(r_in.cur_minutes), 7'd0,
                            cdfa_pkg::MIN_TOP, 7'd0, r_in.direction));
                    end
                    default: begin
                        n_out.new_seconds = 6'(cdfa_pkg::f_step(7'(r_in.cur_seconds), 7'd0,
                            cdfa_pkg::MIN_TOP, 7'd0, r_in.direction));
                    end
                endcase
            end else begin
                n_out.write_date = 1'b1;
                n_out.new_day    = r_in.cur_day;
                n_out.new_month  = r_in.cur_month;
                n_out.new_year   = r_in.cur_year;
                case (cdfa_pkg::t_unit'(r_in.unit_select))
                    cdfa_pkg::UNIT_HOUR_DAY: begin
                        n_out.new_day = 5'(cdfa_pkg::f_step(7'(r_in.cur_day), 7'd1,
                            7'(day_lim), 7'd1, r_in.direction));
                    end
                    cdfa_pkg::UNIT_MIN_MONTH: begin
                        // a month change restarts the day at the first
                        n_out.new_month = 4'(cdfa_pkg::f_step(7'(r_in.cur_month), 7'd1,
                            cdfa_pkg::MONTH_TOP, 7'd1, r_in.direction));
                        n_out.new_day   = 5'd1;
                    end
                    default: begin
                        n_out.new_year = cdfa_pkg::f_step(r_in.cur_year, 7'd0,
                            cdfa_pkg::YEAR_TOP, 7'd1, r_in.direction);
                    end
                endcase
            end
        end
        n_out.screen = n_screen;
    end

    // Input register: take a new beat whenever there is room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in <= in_item;
        end
    end

    // Result register and screen state: advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_screen    <= cdfa_pkg::SCREEN_TIME;
        end else if (out_take) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_screen <= n_screen;
            end
        end
        if (out_take && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_screen      = r_out.screen;
    assign o_write_time  = r_out.write_time;
    assign o_write_date  = r_out.write_date;
    assign o_new_hours   = r_out.new_hours;
    assign o_new_minutes = r_out.new_minutes;
    assign o_new_seconds = r_out.new_seconds;
    assign o_new_day     = r_out.new_day;
    assign o_new_month   = r_out.new_month;
    assign o_new_year    = r_out.new_year;

`ifndef SYNTHESIS
    // Only one group is ever written back
    a_one_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_write_time && o_write_date))
        else $error("both write groups set");

    // A time write comes from the time screen, a date write from the date screen
    a_group_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_write_time || o_write_date) |-> o_write_date == o_screen)
        else $error("write group does not match screen");

    // Unused time fields read as zero
    a_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_time |->
            o_new_hours == 5'd0 && o_new_minutes == 6'd0 && o_new_seconds == 6'd0)
        else $error("time fields not cleared");

    // Screen state only changes when an event moves into the result register
    a_screen_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_valid && out_take) |=> $stable(r_screen))
        else $error("screen changed without an event");
`endif

endmodule
